// ----- sv/deq_pkg.sv -----
// Shared types, constants and an index helper for the double-ended queue.
// No dependencies; the queue top, the sequencer and the bench import this package.
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;

    localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP_FWD   = 3'd4,
        OP_DUMP_REV   = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic    fire;
        status_t status;
        logic    use_rdata;
        logic    last;
    } result_t;

    // Sum of two slot indexes, folded back into 0..DEPTH-1.
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] sum);
        logic [IDX_W:0] adj;
        begin
            adj = sum;
            if (sum >= DEPTH_EXT)
            begin
                adj = sum - DEPTH_EXT;
            end
            return adj[IDX_W-1:0];
        end
    endfunction

endpackage

// ----- sv/double_ended_queue.sv -----
// Top level of the bounded double-ended queue: sequencer, slot RAM and the
// output register. Depends on deq_pkg, deq_ctrl and deq_ram.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tuser = opcode, s_tdata = value
//  m_*       out        m_tvalid/m_tready  m_tuser = status, m_tdata = data, m_tlast
//
// A push, a pop or an empty dump is accepted in IDLE and passes through EMIT into
// the output register; the next request is taken once the sequencer is back in IDLE.
// A dump of N entries emits one result per cycle while the output register has
// room, paced by the single RAM read port. A full output register stalls the
// sequencer. Reset clears head and count; slot contents are not cleared.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [OP_W-1:0]   s_tuser,   // [2:0] opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [31:0] data
    output logic [STAT_W-1:0] m_tuser,   // [1:0] status
    output logic              m_tlast
);

    ram_req_t          ram_req;
    result_t           result;
    logic [DATA_W-1:0] rd_data;
    logic              out_free;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0] m_tuser_reg, m_tuser_next;
    logic              m_tlast_reg, m_tlast_next;

    assign out_free = !m_tvalid_reg || m_tready;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .opcode   (s_tuser),
        .value    (s_tdata),
        .out_free (out_free),
        .ram_req  (ram_req),
        .result   (result)
    );

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (result.fire)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = result.use_rdata ? rd_data : '0;
            m_tuser_next  = result.status;
            m_tlast_next  = result.last;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- sv/deq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/deq_ctrl.sv -----
// Request sequencer: decodes operations, keeps head and count, drives the
// slot RAM and walks dumps. Depends on deq_pkg.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   opcode,
    input  logic [DATA_W-1:0] value,
    input  logic              out_free,
    output ram_req_t          ram_req,
    output result_t           result
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;
    logic              use_rdata_reg, use_rdata_next;
    logic              dump_reg, dump_next;
    logic              rev_reg, rev_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic              accept;
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  cnt_m1;
    logic [IDX_W-1:0]  tail_off;
    logic [IDX_W-1:0]  step_idx;
    logic [IDX_W-1:0]  step_off;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign tail_off = cnt_m1[IDX_W-1:0];
    assign step_idx = idx_reg + IDX_W'(1);
    assign step_off = rev_reg ? (tail_off - step_idx) : step_idx;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        use_rdata_next = use_rdata_reg;
        dump_next      = dump_reg;
        rev_next       = rev_reg;
        idx_next       = idx_reg;
        ram_req        = '0;
        ram_req.wr_data = value;
        result.fire      = 1'b0;
        result.status    = status_reg;
        result.use_rdata = use_rdata_reg;
        result.last      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next    = STAT_OK;
                    last_next      = 1'b1;
                    use_rdata_next = 1'b0;
                    dump_next      = 1'b0;
                    unique case (opcode)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            state_next = ST_EMIT;
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_req.wr_en = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                                if (opcode == OP_PUSH_FRONT)
                                begin
                                    head_next = (head_reg == '0) ? LAST_IDX
                                                                 : head_reg - IDX_W'(1);
                                    ram_req.wr_addr = head_next;
                                end
                                else
                                begin
                                    ram_req.wr_addr =
                                        wrap_idx({1'b0, head_reg} + {1'b0, count_reg[IDX_W-1:0]});
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            state_next = ST_EMIT;
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ram_req.rd_en  = 1'b1;
                                use_rdata_next = 1'b1;
                                count_next     = cnt_m1;
                                if (opcode == OP_POP_FRONT)
                                begin
                                    ram_req.rd_addr = head_reg;
                                    head_next = wrap_idx({1'b0, head_reg} + (IDX_W + 1)'(1));
                                end
                                else
                                begin
                                    ram_req.rd_addr =
                                        wrap_idx({1'b0, head_reg} + {1'b0, tail_off});
                                end
                            end
                        end
                        OP_DUMP_FWD, OP_DUMP_REV:
                        begin
                            state_next = ST_EMIT;
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                rev_next        = (opcode == OP_DUMP_REV);
                                dump_next       = 1'b1;
                                idx_next        = '0;
                                use_rdata_next  = 1'b1;
                                last_next       = (count_reg == CNT_W'(1));
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = (opcode == OP_DUMP_REV)
                                    ? wrap_idx({1'b0, head_reg} + {1'b0, tail_off})
                                    : head_reg;
                            end
                        end
                        default:
                        begin
                            // unknown operation: drop the request
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    result.fire = 1'b1;
                    if (dump_reg && !last_reg)
                    begin
                        // advance the walk and fetch the next slot
                        idx_next        = step_idx;
                        last_next       = ((CNT_W'(step_idx) + CNT_W'(1)) == count_reg);
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = wrap_idx({1'b0, head_reg} + {1'b0, step_off});
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        last_reg      <= last_next;
        use_rdata_reg <= use_rdata_next;
        dump_reg      <= dump_next;
        rev_reg       <= rev_next;
        idx_reg       <= idx_next;
    end

endmodule

// ----- bench/double_ended_queue_tb.sv -----
// Self-checking bench for double_ended_queue: a shadow deque predicts every
// response, a checker compares the output stream. Depends on deq_pkg and the RTL.
`timescale 1ns / 1ps

module double_ended_queue_tb
    import deq_pkg::*;
();

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 40;

    // Opcodes the block must ignore without a response.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam logic [DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX  = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] VAL_ONES = 32'hffff_ffff;

    typedef enum int { RX_ALWAYS, RX_RANDOM, RX_PATTERN } rx_mode_t;

    typedef struct {
        status_t           status;
        logic [DATA_W-1:0] data;
        logic              last;
    } deq_resp_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;    // [31:0] value
    logic [OP_W-1:0]   s_tuser;    // [2:0] opcode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;    // [31:0] data
    logic [STAT_W-1:0] m_tuser;    // [1:0] status
    logic              m_tlast;

    // Shadow copy of the deque contents.
    logic [DATA_W-1:0] shadow_slots [DEPTH];
    int                shadow_head  = 0;
    int                shadow_count = 0;
    deq_resp_t         due_responses[$];

    int       mismatch_count = 0;
    int       cycle_count    = 0;
    bit       tx_gaps        = 1'b0;
    int       burst_left     = 0;
    rx_mode_t rx_mode        = RX_ALWAYS;
    int       hold_req       = 0;
    int       hold_seen      = 0;
    int       hold_left      = 0;
    logic [15:0] rx_pattern  = 16'b1011_0001_1110_0101;

    double_ended_queue u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d responses still due", $time, due_responses.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: a long hold-off when requested, otherwise the current stall mode.
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    m_tready   <= rx_pattern[0];
                    rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        deq_resp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_responses.size() == 0)
            begin
                $display("%0t: unexpected response, status %0d data %h last %0d",
                         $time, m_tuser, m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = due_responses.pop_front();
                if (m_tuser !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata !== want.data)
                begin
                    $display("%0t: data expected %h actual %h", $time, want.data, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time, want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic queue_response(input status_t status, input logic [DATA_W-1:0] data,
                                  input logic last);
        due_responses.push_back('{status, data, last});
    endtask

    // Advance the shadow deque by one accepted request and queue its responses.
    task automatic shadow_deque_apply(input logic [OP_W-1:0] op,
                                      input logic [DATA_W-1:0] value);
        int k;
        int pos;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (shadow_count == DEPTH)
                begin
                    queue_response(STAT_FULL, '0, 1'b1);
                end
                else
                begin
                    if (op == OP_PUSH_FRONT)
                    begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        shadow_slots[shadow_head] = value;
                    end
                    else
                    begin
                        shadow_slots[(shadow_head + shadow_count) % DEPTH] = value;
                    end
                    shadow_count++;
                    queue_response(STAT_OK, '0, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (shadow_count == 0)
                begin
                    queue_response(STAT_EMPTY, '0, 1'b1);
                end
                else
                begin
                    if (op == OP_POP_FRONT)
                    begin
                        queue_response(STAT_OK, shadow_slots[shadow_head], 1'b1);
                        shadow_head = (shadow_head + 1) % DEPTH;
                    end
                    else
                    begin
                        pos = (shadow_head + shadow_count - 1) % DEPTH;
                        queue_response(STAT_OK, shadow_slots[pos], 1'b1);
                    end
                    shadow_count--;
                end
            end
            OP_DUMP_FWD, OP_DUMP_REV:
            begin
                if (shadow_count == 0)
                begin
                    queue_response(STAT_EMPTY, '0, 1'b1);
                end
                for (k = 0; k < shadow_count; k++)
                begin
                    pos = (op == OP_DUMP_FWD) ? k : shadow_count - 1 - k;
                    queue_response(STAT_OK, shadow_slots[(shadow_head + pos) % DEPTH],
                                   k == shadow_count - 1);
                end
            end
            default:
            begin
                // spare opcodes: no state change, no response
            end
        endcase
    endtask

    // Offer one request; valid stays high into the next request unless a gap follows.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
        int gap;
        if (tx_gaps && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        shadow_deque_apply(op, value);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 15))
            0:       v = VAL_MIN;
            1:       v = VAL_MAX;
            2:       v = VAL_ONES;
            3:       v = '0;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic test_empty_deque();
        send_request(OP_POP_FRONT, pick_value());
        send_request(OP_POP_BACK, pick_value());
        send_request(OP_DUMP_FWD, pick_value());
        send_request(OP_DUMP_REV, pick_value());
        send_request(OP_SPARE_A, VAL_ONES);
        send_request(OP_SPARE_B, '0);
    endtask

    task automatic test_extreme_values();
        send_request(OP_PUSH_FRONT, VAL_MIN);
        send_request(OP_PUSH_BACK, VAL_MAX);
        send_request(OP_PUSH_FRONT, VAL_ONES);
        send_request(OP_PUSH_BACK, '0);
        send_request(OP_DUMP_FWD, '0);
        send_request(OP_DUMP_REV, VAL_ONES);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_POP_BACK, '0);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_POP_BACK, '0);
    endtask

    // Fill to capacity, hit the full case from both ends, dump, drain, then pop the empty deque.
    task automatic test_fill_and_drain();
        logic [OP_W-1:0] op;
        while (shadow_count < DEPTH)
        begin
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            send_request(op, pick_value());
        end
        send_request(OP_PUSH_FRONT, pick_value());
        send_request(OP_PUSH_BACK, pick_value());
        send_request(OP_DUMP_FWD, pick_value());
        send_request(OP_DUMP_REV, pick_value());
        while (shadow_count > 0)
        begin
            op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            send_request(op, pick_value());
        end
        send_request(OP_POP_FRONT, pick_value());
    endtask

    // Hold the receiver off while the sender keeps offering, so the block stalls.
    task automatic test_backpressure(input int n);
        int i;
        logic [OP_W-1:0] op;
        tx_gaps  = 1'b0;
        hold_req <= hold_req + 1;
        for (i = 0; i < n; i++)
        begin
            op = (i % 5 == 4) ? OP_DUMP_FWD : (i % 2 ? OP_PUSH_BACK : OP_PUSH_FRONT);
            send_request(op, pick_value());
        end
    endtask

    // Fill and drain phases with random content, dumps and spare opcodes mixed in.
    task automatic test_random_traffic(input int n);
        int i;
        int roll;
        bit growing;
        logic [OP_W-1:0] op;
        growing = 1'b1;
        for (i = 0; i < n; i++)
        begin
            if (i % 20 == 0)
            begin
                rx_mode <= rx_mode_t'($urandom_range(0, 2));
                tx_gaps = ($urandom_range(0, 2) != 0);
            end
            if (shadow_count == DEPTH && $urandom_range(0, 2) == 0)
            begin
                growing = 1'b0;
            end
            else if (shadow_count == 0 && $urandom_range(0, 2) == 0)
            begin
                growing = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
            end
            else if (roll < 18)
            begin
                op = $urandom_range(0, 1) ? OP_DUMP_FWD : OP_DUMP_REV;
            end
            else if ((roll < 78) == growing)
            begin
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            end
            else
            begin
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            end
            send_request(op, pick_value());
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_deque();
        rx_mode <= RX_PATTERN;
        tx_gaps = 1'b1;
        test_extreme_values();
        rx_mode <= RX_RANDOM;
        test_fill_and_drain();
        test_backpressure(30);
        test_random_traffic(100);

        s_tvalid <= 1'b0;
        rx_mode  <= RX_RANDOM;
        while (due_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);

        if (mismatch_count == 0 && due_responses.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/deq_pkg.sv
sv/deq_ram.sv
sv/deq_ctrl.sv
sv/double_ended_queue.sv
bench/double_ended_queue_tb.sv
